>>> rtl/insertion_sorter_top_macros.svh
// assertion macros for the insertion sorter
`ifndef INSERTION_SORTER_TOP_MACROS_SVH
`define INSERTION_SORTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ISORT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define ISORT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ISORT_ASSERT(label, clk, rst_n, !(cond), msg)
`else
`define ISORT_ASSERT(label, clk, rst_n, prop, msg)
`define ISORT_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/isort_pkg.sv
// shared types and constants of the insertion sorter
`timescale 1ns / 1ps
package isort_pkg;

  localparam int unsigned VALUE_W = 32;

  // input item
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      final_item;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      end_of_run;
    logic                      overflowed;
  } out_item_t;

  // command classes handed from the front end to the chain
  typedef enum logic [0:0] {
    OP_INSERT      = 1'b0,
    OP_INSERT_LAST = 1'b1
  } isort_op_e;

  typedef struct packed {
    isort_op_e                 op;
    logic signed [VALUE_W-1:0] value;
  } isort_cmd_t;

  // chain control states
  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } isort_state_e;

endpackage

>>> rtl/isort_front.sv
// front end: takes items, classifies them and queues commands for the chain
`timescale 1ns / 1ps
module isort_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  isort_pkg::in_item_t in_item_i,
  output isort_pkg::isort_cmd_t cmd_o,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i
);
  import isort_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  isort_cmd_t         fifo_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               wr_en, rd_en;
  isort_cmd_t         cmd_new;

  // classify the arriving item
  always_comb begin
    cmd_new.value = in_item_i.value;
    cmd_new.op    = in_item_i.final_item ? OP_INSERT_LAST : OP_INSERT;
  end

  // handshakes on both sides of the queue
  assign full        = (cnt_q == CNT_W'(DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign wr_en       = push && !full;
  assign rd_en       = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

>>> rtl/isort_chain.sv
// back end: systolic insertion chain with drain and result register
`timescale 1ns / 1ps
module isort_chain #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  isort_pkg::isort_cmd_t  cmd_i,
  input  logic                   cmd_valid_i,
  output logic                   cmd_ready_o,
  output isort_pkg::out_item_t   out_item_o,
  output logic                   out_valid_o,
  input  logic                   out_take_i
);
  import isort_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic signed [VALUE_W-1:0] cell_q [CAPACITY];
  logic [CAPACITY-1:0]       gt;
  logic [CNT_W-1:0]          count_q, count_d;
  logic                      drop_q, drop_d;
  isort_state_e              state_q, state_d;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_q;
  logic                      cmd_take, store_full, ins_en, move;
  logic                      drain_st, head_ok;

  // control strobes
  assign drain_st    = (state_q == ST_DRAIN);
  assign cmd_ready_o = (state_q == ST_LOAD);
  assign cmd_take    = cmd_valid_i && cmd_ready_o;
  assign store_full  = (count_q == CNT_W'(CAPACITY));
  assign ins_en      = cmd_take && !store_full;
  assign move        = drain_st && (!out_valid_q || out_take_i);

  // one cell per place: insert shifts larger values up, drain shifts all down
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
    logic                      prev_gt;
    logic signed [VALUE_W-1:0] prev_val;
    logic signed [VALUE_W-1:0] next_val;
    logic                      ins_we;
    logic signed [VALUE_W-1:0] ins_val;

    assign gt[g] = (IDX < count_q) && (cell_q[g] > cmd_i.value);

    if (g == 0) begin : g_first
      assign prev_gt  = 1'b0;
      assign prev_val = cmd_i.value;
    end else begin : g_rest
      assign prev_gt  = gt[g-1];
      assign prev_val = cell_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_top
      assign next_val = cell_q[g];
    end else begin : g_mid
      assign next_val = cell_q[g+1];
    end

    // a cell whose lower neighbour moves up takes that neighbour's value
    assign ins_we  = gt[g] || (IDX == count_q);
    assign ins_val = prev_gt ? prev_val : cmd_i.value;

    always_ff @(posedge clk_i) begin
      if (ins_en && ins_we) begin
        cell_q[g] <= ins_val;
      end else if (move) begin
        cell_q[g] <= next_val;
      end
    end
  end

  // fill count, drop flag and state
  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (cmd_take) begin
          if (store_full) begin
            drop_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
          if (cmd_i.op == OP_INSERT_LAST) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (move) begin
          count_d = count_q - CNT_W'(1);
          if (count_q == CNT_W'(1)) begin
            drop_d  = 1'b0;
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // result register
  assign out_valid_d = move ? 1'b1 : (out_take_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drop_q      <= 1'b0;
      state_q     <= ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      drop_q      <= drop_d;
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q.sorted_value <= cell_q[0];
      out_q.end_of_run   <= (count_q == CNT_W'(1));
      out_q.overflowed   <= drop_q;
    end
  end

  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

  // checks
  assign head_ok = (count_q < CNT_W'(2)) || (cell_q[0] <= cell_q[1]);

  `include "insertion_sorter_top_macros.svh"

  `ISORT_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CNT_W'(CAPACITY), "count too high")
  `ISORT_ASSERT_NEVER(a_drain_nonempty, clk_i, rst_ni, drain_st && (count_q == '0), "empty drain")
  `ISORT_ASSERT(a_head_sorted, clk_i, rst_ni, head_ok, "chain head out of order")
  `ISORT_ASSERT(a_drain_fill, clk_i, rst_ni, drain_st && !out_valid_q |=> out_valid_q, "drain stall")

endmodule

>>> rtl/insertion_sorter_top.sv
// top level of the insertion sorter: front queue and insertion chain
//
//   channel   handshake            payload       direction
//   input     push / full          in_item_i     in
//   result    empty / pop          out_item_o    out
//
// an item is registered in the front queue before it enters the chain; the chain
// inserts one item per cycle while not draining, so loading runs at one item per cycle
// an item marked final starts a drain of n results (1 to CAPACITY), one per
// cycle while pop keeps up; no item is inserted during the drain
// the two-entry front queue keeps taking items during a drain until it fills
// reset clears the queue, fill count, drop flag and result valid flag at once;
// no clearing pass
`timescale 1ns / 1ps
module insertion_sorter_top #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  isort_pkg::in_item_t  in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output isort_pkg::out_item_t out_item_o
);
  import isort_pkg::*;

  isort_cmd_t cmd;
  logic       cmd_valid, cmd_ready;
  logic       out_valid, out_take;

  // result side handshake
  assign empty    = !out_valid;
  assign out_take = pop && out_valid;

  // front end
  isort_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  // insertion chain
  isort_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid),
    .out_take_i  (out_take)
  );

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the insertion sorter: sets of values against a sorting predictor
module tb;
  import isort_pkg::*;

  localparam int unsigned SORT_DEPTH   = 32;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_GUARD  = 20;
  localparam int unsigned PHASE_ITEMS  = 98;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  // how the values of one set are drawn
  typedef enum int {
    VAL_WIDE,
    VAL_NARROW,
    VAL_EDGE
  } value_mode_e;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      push      = 1'b0;
  logic      full;
  in_item_t  in_item_i = '0;
  logic      empty;
  logic      pop       = 1'b0;
  out_item_t out_item_o;

  // sorting predictor state
  logic signed [VALUE_W-1:0] sorted_store_q[$];
  logic                      drop_seen = 1'b0;
  out_item_t                 sorted_expect_q[$];

  // stimulus and flow control
  in_item_t pending_q[$];
  int       drv_cnt       = 0;
  int       in_acc_cnt    = 0;
  int       snd_idle_pct  = 0;
  int       rcv_idle_pct  = 0;
  int       hold_req_cnt  = 0;
  int       hold_done_cnt = 0;
  int       hold_left     = 0;
  int       err_cnt       = 0;
  int       stall_cycles  = 0;

  insertion_sorter_top #(
    .CAPACITY (SORT_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // insert one accepted item; a final item releases the whole set in order
  function automatic void sort_in_item(in_item_t it);
    int        pos;
    out_item_t res;
    if (sorted_store_q.size() >= SORT_DEPTH) begin
      drop_seen = 1'b1;
    end else begin
      // equal values stay behind the ones already stored
      pos = 0;
      while (pos < sorted_store_q.size() && sorted_store_q[pos] <= $signed(it.value))
        pos++;
      sorted_store_q.insert(pos, it.value);
    end
    if (it.final_item) begin
      foreach (sorted_store_q[k]) begin
        res.sorted_value = sorted_store_q[k];
        res.end_of_run   = (k == sorted_store_q.size() - 1);
        res.overflowed   = drop_seen;
        sorted_expect_q.push_back(res);
      end
      sorted_store_q.delete();
      drop_seen = 1'b0;
    end
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value(value_mode_e mode);
    logic signed [VALUE_W-1:0] v;
    case (mode)
      VAL_NARROW: v = $signed($urandom_range(0, 6)) - 3;
      VAL_EDGE: begin
        case ($urandom_range(0, 5))
          0:       v = VAL_MIN;
          1:       v = VAL_MAX;
          2:       v = '0;
          3:       v = -1;
          4:       v = VAL_MIN + 1;
          default: v = VAL_MAX - 1;
        endcase
      end
      default:    v = $urandom;
    endcase
    return v;
  endfunction

  function automatic void queue_item(logic signed [VALUE_W-1:0] v, logic fin);
    in_item_t it;
    it.value      = v;
    it.final_item = fin;
    pending_q.push_back(it);
  endfunction

  // one set of len values, the last one marked final
  function automatic void queue_set(int len, value_mode_e mode);
    for (int k = 0; k < len; k++)
      queue_item(pick_value(mode), k == len - 1);
  endfunction

  // sender pauses until every item is in and every result is out
  task automatic wait_drained();
    while (pending_q.size() != 0 || drv_cnt != in_acc_cnt || sorted_expect_q.size() != 0)
      @(negedge clk_i);
  endtask

  // driver: offers the next pending item, holds it until taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (push && drv_cnt != in_acc_cnt) begin
        push <= 1'b1;
      end else if (pending_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        in_item_i <= pending_q.pop_front();
        push      <= 1'b1;
        drv_cnt   = drv_cnt + 1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: random pop, with a long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        pop       <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_done_cnt != hold_req_cnt) begin
        pop           <= 1'b0;
        hold_left     <= HOLD_CYCLES;
        hold_done_cnt <= hold_done_cnt + 1;
      end else begin
        pop <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // monitor: predict on accepted items, check accepted results, watchdog
  always @(posedge clk_i) begin : mon
    out_item_t want;
    logic      moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (push && !full) begin
        sort_in_item(in_item_i);
        in_acc_cnt <= in_acc_cnt + 1;
        moved = 1'b1;
      end
      if (pop && !empty) begin
        moved = 1'b1;
        if (sorted_expect_q.size() == 0) begin
          $display("%0t: result with none waiting, got value %0d last %b ovf %b", $time,
                   $signed(out_item_o.sorted_value), out_item_o.end_of_run,
                   out_item_o.overflowed);
          err_cnt++;
        end else begin
          want = sorted_expect_q.pop_front();
          if (out_item_o.sorted_value !== want.sorted_value) begin
            $display("%0t: sorted_value expected %0d, got %0d", $time,
                     $signed(want.sorted_value), $signed(out_item_o.sorted_value));
            err_cnt++;
          end
          if (out_item_o.end_of_run !== want.end_of_run) begin
            $display("%0t: end_of_run expected %b, got %b", $time,
                     want.end_of_run, out_item_o.end_of_run);
            err_cnt++;
          end
          if (out_item_o.overflowed !== want.overflowed) begin
            $display("%0t: overflowed expected %b, got %b", $time,
                     want.overflowed, out_item_o.overflowed);
            err_cnt++;
          end
        end
      end
      // watchdog on cycles without any item moving
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $time, stall_cycles);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // stimulus
  initial begin
    int          phase_items;
    int          len;
    value_mode_e mode;
    snd_idle_pct = 14;
    rcv_idle_pct = 48;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // single-value sets at both extremes
    queue_item(VAL_MIN, 1'b1);
    queue_item(VAL_MAX, 1'b1);
    // receiver holds off while the drain starts and the next set piles up
    hold_req_cnt = 1;
    // extremes mixed with duplicates, the final value equal to an earlier one
    queue_item(VAL_MAX, 1'b0);
    queue_item(VAL_MIN, 1'b0);
    queue_item('0, 1'b0);
    queue_item(-1, 1'b0);
    queue_item(1, 1'b0);
    queue_item(-1, 1'b0);
    queue_item(VAL_MAX, 1'b0);
    queue_item(VAL_MIN, 1'b1);
    // descending, then ascending input order
    for (int k = 4; k >= 0; k--)
      queue_item(k, k == 0);
    for (int k = -2; k <= 0; k++)
      queue_item(k, k == 0);
    wait_drained();

    // random sets under three idling settings; some sets reach or pass the capacity
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct = 14;
          rcv_idle_pct = 48;
        end
        1: begin
          snd_idle_pct = 48;
          rcv_idle_pct = 14;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 12) begin
          case ($urandom_range(0, 4))
            0:       len = SORT_DEPTH - 1;
            1:       len = SORT_DEPTH;
            2:       len = SORT_DEPTH + 1;
            3:       len = SORT_DEPTH + 2;
            default: len = SORT_DEPTH + 6;
          endcase
        end else begin
          len = $urandom_range(1, 10);
        end
        case ($urandom_range(0, 3))
          0:       mode = VAL_NARROW;
          1:       mode = VAL_EDGE;
          default: mode = VAL_WIDE;
        endcase
        queue_set(len, mode);
        phase_items += len;
      end
      wait_drained();
    end

    // let any stray result show up before the verdict
    repeat (DRAIN_GUARD) @(negedge clk_i);
    if (err_cnt == 0 && sorted_expect_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
